[hdl/gkni_pkg.sv]
// Shared types, codes and counter helpers for the gapped k-mer node index.
package gkni_pkg;

  // Item kinds carried in the input tuser field
  localparam logic [1:0] MODE_INDEX = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_STATS = 2'd2;

  localparam int NODE_ID_W = 10;
  localparam int OCC_W     = 16;
  localparam int CNT_W     = 32;

  // One k-mer store entry: duplicate mark, owner node, occurrence count
  typedef struct packed {
    logic                 dup;
    logic [NODE_ID_W-1:0] own;
    logic [OCC_W-1:0]     occ;
  } kent_t;

  // One node store entry
  typedef struct packed {
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] dup;
    logic [CNT_W-1:0] uniq;
  } node_cnt_t;

  // Read-modify-write operations on a node entry
  typedef enum logic [2:0] {
    NOP_READ,
    NOP_UNIQ,
    NOP_DUP,
    NOP_MOVE,
    NOP_HIT
  } node_op_t;

  // Map an ASCII letter to a two-bit base, anything else to A
  function automatic logic [1:0] letter_code(input logic [7:0] c);
    logic [1:0] b;
    case (c)
      "C", "c": b = 2'd1;
      "G", "g": b = 2'd2;
      "T", "t": b = 2'd3;
      default:  b = 2'd0;
    endcase
    return b;
  endfunction

  // Map a one-hot nibble to a two-bit base, anything else to A
  function automatic logic [1:0] nib_code(input logic [3:0] n);
    logic [1:0] b;
    case (n)
      4'h2:    b = 2'd1;
      4'h4:    b = 2'd2;
      4'h8:    b = 2'd3;
      default: b = 2'd0;
    endcase
    return b;
  endfunction

  // Add with saturation at all ones
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  // Apply one operation to a node entry
  function automatic node_cnt_t node_update(input node_op_t op, input node_cnt_t c,
                                            input logic [OCC_W-1:0] occ);
    node_cnt_t        r;
    logic [CNT_W-1:0] occ_w;
    r     = c;
    occ_w = CNT_W'(occ);
    case (op)
      NOP_UNIQ: r.uniq = sat_add(c.uniq, CNT_W'(1));
      NOP_DUP:  r.dup  = sat_add(c.dup, CNT_W'(1));
      NOP_MOVE: begin
        r.uniq = (c.uniq > occ_w) ? (c.uniq - occ_w) : '0;
        r.dup  = sat_add(c.dup, occ_w);
      end
      NOP_HIT:  r.hits = sat_add(c.hits, CNT_W'(1));
      default:  r = c;
    endcase
    return r;
  endfunction

endpackage

[hdl/gapped_kmer_node_index.sv]
// Gapped k-mer node index: rolling k-mer, owner store and per-node counters.
//
// One base arrives per input transfer; s_tuser selects index, query or stats.
// The block works on one item at a time and takes no new item until the
// last one is loaded into the output register. An item goes from idle
// straight to the output state when no store is visited (unused mode, stats
// of an out-of-range node, or k-mer not yet filled). Otherwise it passes, as
// needed, the k-mer state (index or query with a filled k-mer), the first
// node state (stats read, query hit, or index for a valid non-zero node) and
// the second node state (an index that makes a k-mer shared and moves the
// earlier owner's count) before the output state. The result is loaded in
// the output state, and the next item can be accepted in the cycle in which
// m_tvalid rises. This sequence is set by the read-modify-write passes
// through the k-mer store and the node counter store, each with one read and
// one write port and a registered read. A finished result sits in the
// output register while the next item is taken; a second finished result
// waits until that register frees up. After reset a clearing pass over
// max(4**K_BASES, NODE_SLOTS) entries zeroes both stores; no input is taken until it ends.
module gapped_kmer_node_index
  import gkni_pkg::*;
#(
  parameter int K_BASES    = 10,
  parameter int NODE_SLOTS = 1024,
  localparam int KW        = 2 * K_BASES,
  localparam int OUT_BITS  = 3 * CNT_W + 2 + NODE_ID_W + KW,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  // s_tdata: new_sequence[0], letter[8:1], nibble[12:9], node_id[22:13]
  input  logic [23:0]      s_tdata,
  // s_tuser: mode[1:0]
  input  logic [1:0]       s_tuser,
  input  logic             s_tvalid,
  output logic             s_tready,
  // m_tdata: kmer_ready, gapped_kmer, owner_node, is_duplicate,
  //          unique_count, dup_count, query_hits, then zero fill
  output logic [OUT_W-1:0] m_tdata,
  output logic             m_tvalid,
  input  logic             m_tready
);

  localparam int KSPACE   = 1 << KW;
  localparam int NAW      = $clog2(NODE_SLOTS);
  localparam int FW       = $clog2(K_BASES + 1);
  localparam int CW       = (KW > NAW) ? KW : NAW;
  localparam int CLR_LEN  = (KSPACE > NODE_SLOTS) ? KSPACE : NODE_SLOTS;
  localparam logic [CW-1:0] CLR_LAST = CW'(CLR_LEN - 1);
  localparam logic [KW-1:0] GAPMASK  =
    ~((KW'(3) << (2 * (K_BASES / 3))) | (KW'(3) << (2 * ((2 * K_BASES) / 3))));

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_KMER,
    S_NODE_A,
    S_NODE_B,
    S_OUT
  } state_t;

  // Decision taken once the k-mer entry is read
  typedef struct packed {
    logic           kwe;
    kent_t          kwdata;
    logic           go_node;
    logic [NAW-1:0] a;
    node_op_t       a_op;
    logic           have_b;
    logic [NAW-1:0] b;
    node_op_t       b_op;
    logic           dup_out;
    logic [NODE_ID_W-1:0] own_out;
  } kdec_t;

  state_t state;

  // Stores
  kent_t     kmem [KSPACE];
  node_cnt_t nmem [NODE_SLOTS];
  kent_t     kq;
  node_cnt_t nq;

  // Rolling k-mer and clearing counter
  logic [KW-1:0] rolling;
  logic [FW-1:0] fill;
  logic [CW-1:0] clr;

  // Item registers
  logic [1:0]           cur_mode;
  logic [NODE_ID_W-1:0] node_reg;
  logic                 node_ok;
  logic [KW-1:0]        km_reg;
  logic                 ready_reg;
  logic [OCC_W-1:0]     occ_reg;
  logic [NAW-1:0]       node_a;
  logic [NAW-1:0]       node_b;
  node_op_t             op_a;
  node_op_t             op_b;
  logic                 have_b;
  logic [NODE_ID_W-1:0] res_own;
  logic                 res_dup;
  node_cnt_t            res_cnt;

  // Input fields
  logic [1:0]           in_mode;
  logic                 in_newseq;
  logic [7:0]           in_letter;
  logic [3:0]           in_nibble;
  logic [NODE_ID_W-1:0] in_node;
  logic                 accept;

  assign in_mode   = s_tuser;
  assign in_newseq = s_tdata[0];
  assign in_letter = s_tdata[8:1];
  assign in_nibble = s_tdata[12:9];
  assign in_node   = s_tdata[22:13];
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // Shift the new base into the rolling k-mer
  logic [1:0]    base;
  logic          shifts;
  logic [KW-1:0] roll_src;
  logic [FW-1:0] fill_src;
  logic [KW-1:0] roll_next;
  logic [FW-1:0] fill_next;
  logic [KW-1:0] km_next;
  logic          ready_next;
  logic          in_node_range;

  always_comb begin
    base      = (in_mode == MODE_INDEX) ? letter_code(in_letter) : nib_code(in_nibble);
    shifts    = (in_mode == MODE_INDEX) || (in_mode == MODE_QUERY);
    roll_src  = in_newseq ? '0 : rolling;
    fill_src  = in_newseq ? '0 : fill;
    roll_next = rolling;
    fill_next = fill;
    if (shifts) begin
      roll_next = {roll_src[KW-3:0], base};
      fill_next = (32'(fill_src) < K_BASES) ? (fill_src + FW'(1)) : fill_src;
    end
    km_next       = roll_next & GAPMASK;
    ready_next    = (32'(fill_next) >= K_BASES);
    in_node_range = (32'(in_node) < NODE_SLOTS);
  end

  // Decide the k-mer entry update and the node operations
  kdec_t kd;
  logic  own_zero;
  logic  own_self;
  logic  own_range;

  always_comb begin
    own_zero   = !kq.dup && (kq.own == '0);
    own_self   = !kq.dup && (kq.own == node_reg);
    own_range  = (32'(kq.own) < NODE_SLOTS);
    kd         = '0;
    kd.kwdata  = kq;
    kd.a       = NAW'(node_reg);
    kd.a_op    = NOP_UNIQ;
    kd.b       = NAW'(node_reg);
    kd.b_op    = NOP_DUP;
    if (cur_mode == MODE_INDEX) begin
      if (node_ok) begin
        kd.kwe     = 1'b1;
        kd.go_node = 1'b1;
        if (!own_zero && !own_self) begin
          kd.kwdata  = '{dup: 1'b1, own: '0, occ: kq.occ};
          kd.dup_out = 1'b1;
          if (!kq.dup && own_range) begin
            kd.a      = NAW'(kq.own);
            kd.a_op   = NOP_MOVE;
            kd.have_b = 1'b1;
          end else begin
            kd.a_op = NOP_DUP;
          end
        end else begin
          kd.kwdata = '{dup: 1'b0, own: node_reg,
                        occ: (kq.occ != {OCC_W{1'b1}}) ? (kq.occ + OCC_W'(1)) : kq.occ};
        end
      end else begin
        kd.dup_out = kq.dup;
      end
    end else begin
      if (kq.dup) begin
        kd.dup_out = 1'b1;
      end else if (!own_zero && own_range) begin
        kd.own_out = kq.own;
        kd.go_node = 1'b1;
        kd.a       = NAW'(kq.own);
        kd.a_op    = NOP_HIT;
      end
    end
  end

  // Select store addresses and write data
  logic           kwe;
  logic [KW-1:0]  kwaddr;
  kent_t          kwdata;
  logic           nre;
  logic [NAW-1:0] nraddr;
  logic           nwe;
  logic [NAW-1:0] nwaddr;
  node_cnt_t      nwdata;

  always_comb begin
    kwe    = 1'b0;
    kwaddr = km_reg;
    kwdata = kd.kwdata;
    nre    = 1'b0;
    nraddr = node_a;
    nwe    = 1'b0;
    nwaddr = node_a;
    nwdata = node_update(op_a, nq, occ_reg);
    case (state)
      S_CLEAR: begin
        kwe    = (32'(clr) < KSPACE);
        kwaddr = KW'(clr);
        kwdata = '0;
        nwe    = (32'(clr) < NODE_SLOTS);
        nwaddr = NAW'(clr);
        nwdata = '0;
      end
      S_IDLE: begin
        nre    = accept && (in_mode == MODE_STATS) && in_node_range;
        nraddr = NAW'(in_node);
      end
      S_KMER: begin
        kwe    = kd.kwe;
        nre    = kd.go_node;
        nraddr = kd.a;
      end
      S_NODE_A: begin
        nwe    = (op_a != NOP_READ);
        nre    = have_b;
        nraddr = node_b;
      end
      S_NODE_B: begin
        nwe    = 1'b1;
        nwaddr = node_b;
        nwdata = node_update(op_b, nq, occ_reg);
      end
      default: begin
        kwe = 1'b0;
      end
    endcase
  end

  // K-mer store: registered read, one write port
  always_ff @(posedge clk) begin
    if (accept) begin
      kq <= kmem[km_next];
    end
    if (kwe) begin
      kmem[kwaddr] <= kwdata;
    end
  end

  // Node store: registered read, one write port
  always_ff @(posedge clk) begin
    if (nre) begin
      nq <= nmem[nraddr];
    end
    if (nwe) begin
      nmem[nwaddr] <= nwdata;
    end
  end

  // Sequence each item and hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      rolling  <= '0;
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Drop a transferred result unless the output state reloads it
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + CW'(1);
          if (clr == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rolling   <= roll_next;
            fill      <= fill_next;
            cur_mode  <= in_mode;
            node_reg  <= in_node;
            node_ok   <= in_node_range && (in_node != '0);
            km_reg    <= km_next;
            ready_reg <= ready_next;
            node_a    <= NAW'(in_node);
            op_a      <= NOP_READ;
            have_b    <= 1'b0;
            res_own   <= '0;
            res_dup   <= 1'b0;
            res_cnt   <= '0;
            if (ready_next && ((in_mode == MODE_INDEX) || (in_mode == MODE_QUERY))) begin
              state <= S_KMER;
            end else if ((in_mode == MODE_STATS) && in_node_range) begin
              state <= S_NODE_A;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_KMER: begin
          res_dup <= kd.dup_out;
          res_own <= kd.own_out;
          occ_reg <= kq.occ;
          node_a  <= kd.a;
          op_a    <= kd.a_op;
          node_b  <= kd.b;
          op_b    <= kd.b_op;
          have_b  <= kd.have_b;
          state   <= kd.go_node ? S_NODE_A : S_OUT;
        end
        S_NODE_A: begin
          if (op_a == NOP_READ) begin
            res_cnt <= nq;
          end
          state <= have_b ? S_NODE_B : S_OUT;
        end
        S_NODE_B: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= OUT_W'({res_cnt.hits, res_cnt.dup, res_cnt.uniq,
                                res_dup, res_own, km_reg, ready_reg});
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted item always starts work
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not leave idle");

  // The two node updates of one item never hit the same entry
  a_node_b_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == S_NODE_B) |-> (node_a != node_b))
    else $error("second node update aliases the first");

  // Fill count saturates at the k-mer length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (32'(fill) <= K_BASES))
    else $error("fill count beyond k-mer length");

  // A result appears only from the output state
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_OUT))
    else $error("result loaded outside output state");
`endif

endmodule
